### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the duplicate frame filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, ck, rn, prop)
`define ASSERT_NEVER(lbl, ck, rn, cond)
`endif

`endif

### rtl/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Types and constants of the flood duplicate frame filter.
// ----------------------------------------------------------------------------
package ffd_pkg;

	localparam int ADDR_W  = 48;
	localparam int SEQ_W   = 8;
	localparam int WSIZE_W = 7;

	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd50;

	// Verdict codes
	localparam logic [2:0] V_CTRL    = 3'd0;
	localparam logic [2:0] V_OWN     = 3'd1;
	localparam logic [2:0] V_DUP     = 3'd2;
	localparam logic [2:0] V_TTL     = 3'd3;
	localparam logic [2:0] V_FWD     = 3'd4;
	localparam logic [2:0] V_DELIVER = 3'd5;

	// Register indexes (paddr[3])
	localparam logic REG_OWN_ADDR    = 1'b0;
	localparam logic REG_WINDOW_SIZE = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] src;
		logic [SEQ_W-1:0]  seq;
	} entry_t;

endpackage

### rtl/flood_duplicate_frame_filter.sv
// ----------------------------------------------------------------------------
// flood_duplicate_frame_filter
// Classifies received frame headers and suppresses duplicates with a window
// of recent (source, sequence) pairs kept in a ring buffer in RAM.
// ----------------------------------------------------------------------------
// Channel   | Dir | Handshake        | Content
// s_*       | in  | s_tvalid/tready  | one frame header item
// m_*       | out | m_tvalid/tready  | one verdict item
// APB       | in  | psel/penable     | own_address @0x0, window_size @0x8
//
// Control and own-address items go straight to ST_FINISH, which loads their
// verdict into the output register. A data item reads one window entry per
// cycle in ST_SEARCH, then goes to ST_FINISH on a miss or through ST_SHIFT on
// a duplicate; s_tready returns at the same edge that loads the verdict. A
// duplicate shifts later entries down in the same pass. A stalled m_tready holds
// one verdict in the output register and one in ST_FINISH with s_tready low.
// Reset returns all registers to their defaults but leaves the RAM as it is.
`include "assert_macros.svh"

module flood_duplicate_frame_filter #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// header items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // src_addr[47:0], seq_num[55:48], ttl_ended[56],
	                              // forward_enable[57], zero fill above
	input  logic [0:0]  s_tuser,  // is_data[0]
	// verdict items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // verdict[2:0], zero fill above
);

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W = (CNT_W > ffd_pkg::WSIZE_W) ? CNT_W : ffd_pkg::WSIZE_W;
	localparam int ENT_W = $bits(ffd_pkg::entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	state_t                        state_q;
	logic [ffd_pkg::ADDR_W-1:0]    own_q;
	logic [ffd_pkg::WSIZE_W-1:0]   wsize_q;
	logic [CNT_W-1:0]              fill_q;
	logic [IDX_W-1:0]              head_q;
	logic [CNT_W-1:0]              rd_idx_q;
	logic                          rvalid_s1;
	logic [CNT_W-1:0]              cmp_idx_s1;
	logic [ffd_pkg::ADDR_W-1:0]    src_q;
	logic [ffd_pkg::SEQ_W-1:0]     seq_q;
	logic                          ttl_q;
	logic                          fwd_q;
	logic [2:0]                    verdict_q;
	logic                          m_tvalid_q;
	logic [7:0]                    m_tdata_q;

	logic                          cfg_wr;
	logic [CMP_W-1:0]              ws_ext;
	logic [CNT_W-1:0]              cap;
	logic                          in_acc;
	logic                          issue;
	logic                          hit;
	logic                          search_done;
	logic                          out_free;
	logic                          out_load;
	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [ENT_W-1:0]              ram_wdata;
	logic [ENT_W-1:0]              ram_rdata;
	ffd_pkg::entry_t               rd_entry;
	ffd_pkg::entry_t               new_entry;

	// Map a position in the window (0 = oldest) onto a RAM address.
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
	                                          input logic [CNT_W-1:0] l);
		logic [CNT_W:0] s;
		s = {1'b0, CNT_W'(h)} + {1'b0, l};
		if (s >= (CNT_W+1)'(WINDOW_DEPTH)) begin
			s = s - (CNT_W+1)'(WINDOW_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == ffd_pkg::REG_WINDOW_SIZE) ?
		{57'd0, wsize_q} : {16'd0, own_q};

	// Capacity: size zero counts as one, sizes above the RAM depth clamp.
	assign ws_ext = CMP_W'(wsize_q);
	always_comb begin
		if (wsize_q == '0) begin
			cap = CNT_W'(1);
		end else if (ws_ext > CMP_W'(WINDOW_DEPTH)) begin
			cap = CNT_W'(WINDOW_DEPTH);
		end else begin
			cap = CNT_W'(ws_ext);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_FINISH) && out_free;

	// Walk the window: one read issued per cycle, compared the cycle after.
	assign issue = ((state_q == ST_SEARCH) || (state_q == ST_SHIFT)) && (rd_idx_q < fill_q);

	assign rd_entry  = ffd_pkg::entry_t'(ram_rdata);
	assign new_entry = '{src: src_q, seq: seq_q};

	assign hit = (state_q == ST_SEARCH) && rvalid_s1 &&
		(rd_entry.src == src_q) && (rd_entry.seq == seq_q);
	assign search_done = (state_q == ST_SEARCH) && !rvalid_s1 && (rd_idx_q >= fill_q);

	// RAM write: move later entries down after a hit, then put the header at
	// the newest place; on a miss append, evicting the oldest when full.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, fill_q);
		ram_wdata = ENT_W'(new_entry);
		if (state_q == ST_SHIFT) begin
			ram_we = 1'b1;
			if (rvalid_s1) begin
				ram_waddr = phys(head_q, cmp_idx_s1 - CNT_W'(1));
				ram_wdata = ram_rdata;
			end else begin
				ram_waddr = phys(head_q, fill_q - CNT_W'(1));
			end
		end else if (search_done) begin
			ram_we = 1'b1;
		end
	end

	ffd_ram #(
		.WIDTH (ENT_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (phys(head_q, rd_idx_q)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			own_q      <= '0;
			wsize_q    <= ffd_pkg::WSIZE_RESET;
			fill_q     <= '0;
			head_q     <= '0;
			rd_idx_q   <= '0;
			rvalid_s1  <= 1'b0;
			cmp_idx_s1 <= '0;
			src_q      <= '0;
			seq_q      <= '0;
			ttl_q      <= 1'b0;
			fwd_q      <= 1'b0;
			verdict_q  <= ffd_pkg::V_CTRL;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			rvalid_s1  <= issue;
			cmp_idx_s1 <= rd_idx_q;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			// load a finished verdict, or retire the one that was taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {5'd0, verdict_q};
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						src_q    <= s_tdata[47:0];
						seq_q    <= s_tdata[55:48];
						ttl_q    <= s_tdata[56];
						fwd_q    <= s_tdata[57];
						rd_idx_q <= '0;
						if (!s_tuser[0]) begin
							verdict_q <= ffd_pkg::V_CTRL;
							state_q   <= ST_FINISH;
						end else if (s_tdata[47:0] == own_q) begin
							verdict_q <= ffd_pkg::V_OWN;
							state_q   <= ST_FINISH;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						verdict_q <= ffd_pkg::V_DUP;
						state_q   <= ST_SHIFT;
					end else if (search_done) begin
						// evict the oldest when full: advance head, keep fill
						if (fill_q >= cap) begin
							head_q <= phys(head_q, CNT_W'(1));
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
						if (ttl_q) begin
							verdict_q <= ffd_pkg::V_TTL;
						end else if (fwd_q) begin
							verdict_q <= ffd_pkg::V_FWD;
						end else begin
							verdict_q <= ffd_pkg::V_DELIVER;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_SHIFT: begin
					if (!rvalid_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// configuration writes must arrive only while idle; the block itself does not enforce this
			if (cfg_wr) begin
				if (paddr[3] == ffd_pkg::REG_OWN_ADDR) begin
					own_q <= pwdata[47:0];
				end else begin
					wsize_q <= pwdata[6:0];
					fill_q  <= '0;
					head_q  <= '0;
				end
			end
		end
	end

	`ASSERT_AT(a_fill_cap, clk, arst_n, fill_q <= cap)
	`ASSERT_AT(a_cmp_in_window, clk, arst_n, rvalid_s1 |-> (cmp_idx_s1 < fill_q))
	`ASSERT_NEVER(a_no_wr_idle, clk, arst_n, ram_we && (state_q == ST_IDLE || state_q == ST_FINISH))
	`ASSERT_AT(a_ctrl_fast, clk, arst_n, (in_acc && !s_tuser[0]) |=> (state_q == ST_FINISH))
	`ASSERT_AT(a_verdict_code, clk, arst_n, m_tvalid |-> (m_tdata[2:0] <= ffd_pkg::V_DELIVER))

endmodule

### rtl/ffd_ram.sv
// ----------------------------------------------------------------------------
// ffd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ffd_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for flood_duplicate_frame_filter. Headers are streamed in while a
// behavioral model of the recent-header window predicts each verdict. Every
// verdict that leaves the block is checked in order against those predictions.
// The run goes through several window sizes, own addresses and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_DEPTH  = 64;
	localparam int PHASE_HDRS = 200;
	localparam int REPORT_MAX = 10;

	// Byte addresses of the two registers (8 bytes apart, index in paddr[3])
	localparam logic [3:0] ADDR_OWN   = {ffd_pkg::REG_OWN_ADDR, 3'b000};
	localparam logic [3:0] ADDR_WSIZE = {ffd_pkg::REG_WINDOW_SIZE, 3'b000};

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic                       is_data;
		logic [ffd_pkg::ADDR_W-1:0] src;
		logic [ffd_pkg::SEQ_W-1:0]  seq;
		logic                       ttl_ended;
		logic                       fwd_en;
	} hdr_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [63:0] pwdata   = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;  // src_addr[47:0], seq_num[55:48], ttl_ended[56],
	                             // forward_enable[57], zero fill above
	logic [0:0]  s_tuser  = '0;  // is_data[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // verdict[2:0], zero fill above

	// Model of the block: registers and the window, oldest entry at index 0
	logic [ffd_pkg::ADDR_W-1:0]  own_addr_r = '0;
	logic [ffd_pkg::WSIZE_W-1:0] win_size_r = ffd_pkg::WSIZE_RESET;
	ffd_pkg::entry_t             win_q[$];

	logic [2:0]                  verdict_q[$];  // verdicts still to come out, oldest first
	logic [ffd_pkg::ADDR_W-1:0]  pool_addr[4];  // sources that recur within one phase
	int                          n_keys = 8;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          hold_left      = 0;     // receiver hold-off, counted down in cycles
	int          fail_count     = 0;
	int          hdrs_sent      = 0;
	int          verdict_count[6];
	int          size_writes    = 0;

	flood_duplicate_frame_filter #(
		.WINDOW_DEPTH(WIN_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
	endtask

	function automatic logic [ffd_pkg::ADDR_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[ffd_pkg::ADDR_W-1:0];
	endfunction

	function automatic hdr_t mk_hdr(input logic is_data,
	                                input logic [ffd_pkg::ADDR_W-1:0] src,
	                                input logic [ffd_pkg::SEQ_W-1:0] seq,
	                                input logic ttl_ended, input logic fwd_en);
		hdr_t h;
		h.is_data   = is_data;
		h.src       = src;
		h.seq       = seq;
		h.ttl_ended = ttl_ended;
		h.fwd_en    = fwd_en;
		return h;
	endfunction

	// Classify one accepted header and update the window the way the block does.
	function automatic logic [2:0] classify_header(input hdr_t h);
		int              cap;
		ffd_pkg::entry_t e;
		cap = int'(win_size_r);
		if (cap < 1) cap = 1;
		if (cap > WIN_DEPTH) cap = WIN_DEPTH;
		e.src = h.src;
		e.seq = h.seq;
		if (!h.is_data) return ffd_pkg::V_CTRL;
		// own-address drop comes before the duplicate search
		if (h.src == own_addr_r) return ffd_pkg::V_OWN;
		foreach (win_q[k]) begin
			if (win_q[k] == e) begin
				// duplicate: move the entry to the newest position
				win_q.delete(k);
				win_q = {win_q, e};
				return ffd_pkg::V_DUP;
			end
		end
		while (win_q.size() >= cap && win_q.size() > 0) win_q.delete(0);
		win_q = {win_q, e};
		if (h.ttl_ended) return ffd_pkg::V_TTL;
		if (h.fwd_en) return ffd_pkg::V_FWD;
		return ffd_pkg::V_DELIVER;
	endfunction

	// Offer one header, hold it until accepted, then record its verdict.
	// Called right after a rising edge; s_tvalid only drops when a gap is taken.
	task automatic send_header(input hdr_t h);
		logic [2:0] v;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, h.fwd_en, h.ttl_ended, h.seq, h.src};
		s_tuser  <= h.is_data;
		do @(posedge clk); while (!s_tready);
		v = classify_header(h);
		verdict_q = {verdict_q, v};
		verdict_count[v]++;
		hdrs_sent++;
	endtask

	// Drop s_tvalid and wait until every predicted verdict has come out.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_OWN) begin
			own_addr_r = data[ffd_pkg::ADDR_W-1:0];
		end else if (addr == ADDR_WSIZE) begin
			win_size_r = data[ffd_pkg::WSIZE_W-1:0];
			win_q.delete();  // a size write empties the window
			size_writes++;
		end
	endtask

	task automatic read_reg(input logic [3:0] addr, input logic [63:0] want);
		logic [63:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			note_failure($sformatf("register 0x%0h read: expected 0x%0h, got 0x%0h",
			                       addr, want, got));
		end
	endtask

	// Write both registers while the block is idle, then read them back.
	task automatic configure(input logic [ffd_pkg::ADDR_W-1:0] own,
	                         input logic [ffd_pkg::WSIZE_W-1:0] size);
		wait_idle();
		write_reg(ADDR_OWN, {16'b0, own});
		write_reg(ADDR_WSIZE, {57'b0, size});
		read_reg(ADDR_OWN, {16'b0, own_addr_r});
		read_reg(ADDR_WSIZE, {57'b0, win_size_r});
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 76;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 76;
			end
			default: begin
				send_idle_pct  = 16;
				recv_stall_pct = 16;
			end
		endcase
	endtask

	// Mostly recurring (source, sequence) keys so duplicates, moves and evictions
	// happen often; the rest is control traffic, own frames and unrelated noise.
	function automatic hdr_t random_header();
		hdr_t        h;
		int unsigned r;
		int unsigned k;
		r = $urandom_range(99);
		h.ttl_ended = ($urandom_range(99) < 30);
		h.fwd_en    = 1'($urandom_range(1));
		h.src       = rand48();
		h.seq       = 8'($urandom_range(255));
		h.is_data   = 1'b1;
		if (r < 10) begin
			h.is_data = 1'b0;
			if ($urandom_range(1)) h.src = pool_addr[2'($urandom_range(3))];
		end else if (r < 15) begin
			h.src = own_addr_r;
		end else if (r >= 25) begin
			k     = $urandom_range(n_keys - 1);
			h.src = pool_addr[2'(k % 4)];
			h.seq = 8'(k / 4);
		end
		return h;
	endfunction

	// Receiver: check each verdict against the oldest prediction, then drive
	// m_tready for the next cycle (held low while a hold-off is running).
	always @(posedge clk) begin
		logic [2:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				note_failure($sformatf("verdict %0d with none expected", m_tdata[2:0]));
			end else begin
				want = verdict_q[0];
				verdict_q.delete(0);
				if (m_tdata[2:0] !== want) begin
					note_failure($sformatf("verdict: expected %0d, got %0d",
					                       want, m_tdata[2:0]));
				end
			end
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Each verdict kind at least once, duplicate handling ignoring TTL and forwarding,
	// own-address drop taking precedence over a window hit, control frames
	// never touching the window, and field extremes.
	task automatic test_directed_verdicts();
		logic [ffd_pkg::ADDR_W-1:0] ones;
		logic [ffd_pkg::ADDR_W-1:0] mid;
		ones = '1;
		mid  = 48'h1234_5678_9ABC;
		set_idling(IDLE_NONE);
		send_header(mk_hdr(1'b0, '0, 8'd0, 1'b0, 1'b0));
		send_header(mk_hdr(1'b1, '0, 8'd5, 1'b1, 1'b1));
		send_header(mk_hdr(1'b1, ones, 8'd255, 1'b0, 1'b1));
		send_header(mk_hdr(1'b1, ones, 8'd255, 1'b1, 1'b0));
		send_header(mk_hdr(1'b1, ones, 8'd0, 1'b1, 1'b1));
		send_header(mk_hdr(1'b1, mid, 8'd0, 1'b0, 1'b0));
		send_header(mk_hdr(1'b1, mid, 8'd0, 1'b1, 1'b1));
		send_header(mk_hdr(1'b0, ones, 8'd255, 1'b1, 1'b1));
		send_header(mk_hdr(1'b1, ones, 8'd255, 1'b0, 1'b1));
		// own address now matches a source that sits in the window
		wait_idle();
		write_reg(ADDR_OWN, {16'b0, ones});
		read_reg(ADDR_OWN, {16'b0, ones});
		send_header(mk_hdr(1'b1, ones, 8'd255, 1'b0, 1'b1));
		send_header(mk_hdr(1'b0, ones, 8'd0, 1'b0, 1'b1));
		send_header(mk_hdr(1'b1, '0, 8'd5, 1'b0, 1'b0));
	endtask

	// Window of one entry, and a size of zero that behaves as one.
	task automatic test_window_limits();
		logic [ffd_pkg::ADDR_W-1:0] a;
		logic [ffd_pkg::ADDR_W-1:0] b;
		a = 48'h0000_0000_00A1;
		b = 48'h8000_0000_00B2;
		wait_idle();
		write_reg(ADDR_WSIZE, 64'd1);
		send_header(mk_hdr(1'b1, a, 8'd1, 1'b0, 1'b1));
		send_header(mk_hdr(1'b1, b, 8'd1, 1'b0, 1'b1));
		send_header(mk_hdr(1'b1, a, 8'd1, 1'b0, 1'b1));
		send_header(mk_hdr(1'b1, a, 8'd1, 1'b0, 1'b1));
		wait_idle();
		write_reg(ADDR_WSIZE, 64'd0);
		read_reg(ADDR_WSIZE, 64'd0);
		send_header(mk_hdr(1'b1, a, 8'd1, 1'b0, 1'b1));
		send_header(mk_hdr(1'b1, a, 8'd1, 1'b0, 1'b0));
		send_header(mk_hdr(1'b1, b, 8'd1, 1'b1, 1'b0));
		send_header(mk_hdr(1'b1, a, 8'd1, 1'b0, 1'b1));
	endtask

	// Random traffic over several window sizes, own addresses and idling
	// patterns; sizes 0 and above the depth hit the clamps.
	task automatic test_random_traffic();
		int unsigned                sizes[8];
		logic [ffd_pkg::ADDR_W-1:0] own;
		int                         cap;
		sizes = '{64, 127, 1, 0, 7, 33, 100, 64};
		sizes[6] = $urandom_range(2, 127);
		for (int p = 0; p < 8; p++) begin
			set_idling(idle_mode_t'(p % 4));
			own = (p == 0) ? '0 : (p == 1) ? '1 : rand48();
			configure(own, sizes[p][ffd_pkg::WSIZE_W-1:0]);
			foreach (pool_addr[i]) pool_addr[i] = rand48();
			cap = int'(win_size_r);
			if (cap < 1) cap = 1;
			if (cap > WIN_DEPTH) cap = WIN_DEPTH;
			// about half again as many keys as the window holds, to force evictions
			n_keys = cap + cap / 2 + 2;
			repeat (PHASE_HDRS) send_header(random_header());
		end
	endtask

	// Hold the receiver off while headers keep coming, so the block backs up
	// and stalls its input; then release and let it drain.
	task automatic test_output_stall();
		configure(rand48(), 7'd20);
		set_idling(IDLE_NONE);
		n_keys = 32;
		hold_left = 300;
		repeat (150) send_header(random_header());
	endtask

	task automatic finish_run();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (80) @(posedge clk);
		if (verdict_q.size() != 0) begin
			note_failure($sformatf("%0d verdicts never arrived", verdict_q.size()));
		end
		$display("Sent %0d headers over %0d window-size settings with four idling patterns.",
		         hdrs_sent, size_writes);
		$display("Verdicts: ctrl %0d, own %0d, dup %0d, ttl %0d, fwd %0d, deliver %0d;",
		         verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3],
		         verdict_count[4], verdict_count[5]);
		$display("%0d failures.", fail_count);
		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	endtask

	initial begin
		foreach (verdict_count[i]) verdict_count[i] = 0;
		foreach (pool_addr[i]) pool_addr[i] = rand48();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_verdicts();
		test_window_limits();
		test_random_traffic();
		test_output_stall();
		finish_run();
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/ffd_pkg.sv
rtl/ffd_ram.sv
rtl/flood_duplicate_frame_filter.sv
dv/tb_top.sv
